@@ sv/gbp_pkg.sv @@
package gbp_pkg;

    // fixed formats of the data path
    localparam int VALUE_W  = 32;
    localparam int VALUE_F  = VALUE_W - 8;
    localparam int VAR_W    = 48;
    localparam int COEF_W   = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = (VAR_W > VALUE_W) ? VAR_W : VALUE_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_MEAN  = 4'd0,
        CFG_BASE_OMEGA = 4'd1,
        CFG_BASE_ALPHA = 4'd2,
        CFG_BASE_BETA  = 4'd3,
        CFG_FX_MEAN    = 4'd4,
        CFG_FX_OMEGA   = 4'd5,
        CFG_FX_ALPHA   = 4'd6,
        CFG_FX_BETA    = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic                      path_start;
        logic [VAR_W-1:0]          init_base_variance;
        logic [VAR_W-1:0]          init_fx_variance;
        logic signed [VALUE_W-1:0] base_innovation;
        logic signed [VALUE_W-1:0] fx_innovation;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] base_gross_return;
        logic signed [VALUE_W-1:0] cross_gross_return;
    } result_t;

    // clamp a magnitude to the signed value range and apply the sign
    function automatic logic signed [VALUE_W-1:0] sat_mag(input logic [63:0] m,
                                                         input logic neg);
        logic [63:0] lim;
        logic [63:0] v;
        lim = neg ? (64'd1 << (VALUE_W - 1)) : ((64'd1 << (VALUE_W - 1)) - 64'd1);
        v = (m > lim) ? lim : m;
        return neg ? -v[VALUE_W-1:0] : v[VALUE_W-1:0];
    endfunction

endpackage

@@ sv/gbp_lane.sv @@
module gbp_lane
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               path_start,
    input  logic [gbp_pkg::VAR_W-1:0]          init_var,
    input  logic signed [gbp_pkg::VALUE_W-1:0] innovation,
    input  logic signed [gbp_pkg::VALUE_W-1:0] mean,
    input  logic [gbp_pkg::VAR_W-1:0]          omega,
    input  logic [gbp_pkg::COEF_W-1:0]         alpha,
    input  logic [gbp_pkg::COEF_W-1:0]         beta,
    output logic                               busy,
    output logic                               done,
    output logic signed [gbp_pkg::VALUE_W-1:0] gross
);

    localparam int W    = gbp_pkg::VALUE_W;
    localparam int F    = gbp_pkg::VALUE_F;
    localparam int V    = gbp_pkg::VAR_W;
    localparam int C    = gbp_pkg::COEF_W;
    localparam int HW   = V / 2;
    localparam int SQW  = 2 * W;
    localparam int SQH  = SQW / 2;
    localparam int PW   = SQH + C;
    localparam int AW   = SQW + C;
    localparam int CAP  = V + C;
    localparam int ACW  = CAP + 2;
    localparam int SF   = V / 2;
    localparam int RW   = SF + 2;
    localparam int CNTW = $clog2(SF);
    localparam logic [63:0] FLOOR_CALC =
        ((64'd1 << (V - 1)) + 64'd250000000000) / 64'd500000000000;
    localparam logic [V-1:0] FLOOR_RAW =
        (FLOOR_CALC == 64'd0) ? V'(1) : FLOOR_CALC[V-1:0];

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_SQ    = 11'b00000000010,
        ST_AL    = 11'b00000000100,
        ST_AH    = 11'b00000001000,
        ST_AC    = 11'b00000010000,
        ST_BL    = 11'b00000100000,
        ST_BH    = 11'b00001000000,
        ST_SUM   = 11'b00010000000,
        ST_ROOT  = 11'b00100000000,
        ST_EPS   = 11'b01000000000,
        ST_GROSS = 11'b10000000000
    } lane_state_t;

    lane_state_t             state_reg;
    logic [V-1:0]            var_reg;
    logic signed [W-1:0]     shock_reg;
    logic signed [W-1:0]     z_reg;
    logic [SQW-1:0]          sq_reg;
    logic [PW-1:0]           hi_reg;
    logic [ACW-1:0]          acc_reg;
    logic [V-1:0]            x_reg;
    logic [RW-1:0]           rem_reg;
    logic [SF-1:0]           root_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic signed [W-1:0]     gross_reg;
    logic                    done_reg;

    logic [W-1:0]            shock_mag;
    logic [W-1:0]            z_mag;
    logic [AW-1:0]           asq_full;
    logic [CAP:0]            asq_clamp;
    logic [ACW-C-1:0]        sum_shift;
    logic [V-1:0]            var_sat;
    logic [V-1:0]            var_next;
    logic [RW+1:0]           rem_try;
    logic [RW+1:0]           trial;
    logic [SF+W-1:0]         sig_prod;
    logic signed [W+1:0]     gross_wide;
    logic signed [W-1:0]     gross_next;

    // magnitudes of the previous shock and the innovation
    assign shock_mag = shock_reg[W-1] ? W'(-shock_reg) : W'(shock_reg);
    assign z_mag     = z_reg[W-1] ? W'(-z_reg) : W'(z_reg);

    // alpha term, clamped at 2**CAP so that the sum fits the accumulator
    assign asq_full  = {hi_reg, {SQH{1'b0}}} + AW'(acc_reg[PW-1:0]);
    assign asq_clamp = (|asq_full[AW-1:CAP]) ? ((CAP+1)'(1) << CAP)
                                              : {1'b0, asq_full[CAP-1:0]};

    // truncated variance, saturated and floored
    assign sum_shift = acc_reg[ACW-1:C];
    assign var_sat   = (|sum_shift[ACW-C-1:V]) ? {V{1'b1}} : sum_shift[V-1:0];
    assign var_next  = (var_sat < FLOOR_RAW) ? FLOOR_RAW : var_sat;

    // one root bit per cycle
    assign rem_try = {rem_reg, x_reg[V-1:V-2]};
    assign trial   = {2'b00, root_reg, 2'b01};

    assign sig_prod   = root_reg * z_mag;
    assign gross_wide = (W+2)'(64'sd1 <<< F) + (W+2)'(mean) + (W+2)'(shock_reg);
    assign gross_next = (gross_wide > (W+2)'((64'sd1 <<< (W-1)) - 64'sd1))
                        ? {1'b0, {(W-1){1'b1}}}
                        : (gross_wide < -(W+2)'(64'sd1 <<< (W-1)))
                        ? {1'b1, {(W-1){1'b0}}}
                        : gross_wide[W-1:0];

    // sequencer and recursion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            var_reg   <= '0;
            shock_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (path_start)
                        begin
                            var_reg   <= init_var;
                            shock_reg <= '0;
                        end
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:    state_reg <= ST_AL;
                ST_AL:    state_reg <= ST_AH;
                ST_AH:    state_reg <= ST_AC;
                ST_AC:    state_reg <= ST_BL;
                ST_BL:    state_reg <= ST_BH;
                ST_BH:    state_reg <= ST_SUM;
                ST_SUM:
                begin
                    var_reg   <= var_next;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (cnt_reg == CNTW'(SF - 1))
                    begin
                        state_reg <= ST_EPS;
                    end
                end
                ST_EPS:
                begin
                    shock_reg <= gbp_pkg::sat_mag(64'(sig_prod >> SF), z_reg[W-1]);
                    state_reg <= ST_GROSS;
                end
                ST_GROSS:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    z_reg <= innovation;
                end
            end
            ST_SQ:  sq_reg  <= shock_mag * shock_mag;
            ST_AL:  acc_reg <= ACW'(sq_reg[SQH-1:0] * alpha);
            ST_AH:  hi_reg  <= sq_reg[SQW-1:SQH] * alpha;
            ST_AC:  acc_reg <= ACW'(asq_clamp) + ACW'({omega, {C{1'b0}}});
            ST_BL:  acc_reg <= acc_reg + ACW'(var_reg[HW-1:0] * beta);
            ST_BH:  acc_reg <= acc_reg + ACW'({(HW+C)'(var_reg[V-1:HW] * beta), {HW{1'b0}}});
            ST_SUM:
            begin
                x_reg    <= var_next;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_ROOT:
            begin
                x_reg   <= {x_reg[V-3:0], 2'b00};
                cnt_reg <= cnt_reg + CNTW'(1);
                if (rem_try >= trial)
                begin
                    rem_reg  <= RW'(rem_try - trial);
                    root_reg <= {root_reg[SF-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= RW'(rem_try);
                    root_reg <= {root_reg[SF-2:0], 1'b0};
                end
            end
            ST_GROSS: gross_reg <= gross_next;
            default:  ;
        endcase
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign gross = gross_reg;

endmodule

@@ sv/gbp_merge.sv @@
module gbp_merge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic signed [gbp_pkg::VALUE_W-1:0] base_gross,
    input  logic signed [gbp_pkg::VALUE_W-1:0] fx_gross,
    output logic                               busy,
    output logic                               result_valid,
    input  logic                               result_stall,
    output gbp_pkg::result_t                   result
);

    localparam int W = gbp_pkg::VALUE_W;
    localparam int F = gbp_pkg::VALUE_F;

    logic                pend_reg;
    logic                valid_reg;
    logic [2*W-1:0]      prod_reg;
    logic                neg_reg;
    logic signed [W-1:0] bg_reg;
    gbp_pkg::result_t    result_reg;

    logic [W-1:0]        base_mag;
    logic [W-1:0]        fx_mag;
    logic                move;

    assign base_mag = base_gross[W-1] ? W'(-base_gross) : W'(base_gross);
    assign fx_mag   = fx_gross[W-1] ? W'(-fx_gross) : W'(fx_gross);
    assign move     = pend_reg && (!valid_reg || !result_stall);

    // control: product pending and output word held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                pend_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_reg <= 1'b0;
            end
            if (move)
            begin
                valid_reg <= 1'b1;
            end
            else if (valid_reg && !result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // product of the lane results, then the output word
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            prod_reg <= base_mag * fx_mag;
            neg_reg  <= base_gross[W-1] ^ fx_gross[W-1];
            bg_reg   <= base_gross;
        end
        if (move)
        begin
            result_reg.base_gross_return  <= bg_reg;
            result_reg.cross_gross_return <= gbp_pkg::sat_mag(64'(prod_reg >> F), neg_reg);
        end
    end

    assign busy         = pend_reg;
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/garch11_bootstrap_path_step.sv @@
// One GARCH(1,1) step of a base and an FX path per item word. Two identical lanes
// update variance, square root and shock side by side; a merge stage forms the
// cross gross return. From acceptance to its result word an item passes through
// the lane sequencer (squaring, split multiply-add, the bit-per-cycle square
// root, then shock and gross return), then the merge stage. item_stall stays high
// while a step is in flight or its product waits for the output register.
// Configuration: index 0..7 in order base mean, omega, alpha, beta, then FX mean,
// omega, alpha, beta; upper data bits beyond a register's width are dropped,
// other indexes are ignored. cfg_ready is always high.
module garch11_bootstrap_path_step
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  gbp_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output gbp_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int W = gbp_pkg::VALUE_W;
    localparam int V = gbp_pkg::VAR_W;
    localparam int C = gbp_pkg::COEF_W;

    logic signed [W-1:0] base_mean_reg;
    logic [V-1:0]        base_omega_reg;
    logic [C-1:0]        base_alpha_reg;
    logic [C-1:0]        base_beta_reg;
    logic signed [W-1:0] fx_mean_reg;
    logic [V-1:0]        fx_omega_reg;
    logic [C-1:0]        fx_alpha_reg;
    logic [C-1:0]        fx_beta_reg;

    logic                start;
    logic                base_busy;
    logic                fx_busy;
    logic                base_done;
    logic                fx_done;
    logic signed [W-1:0] base_gross;
    logic signed [W-1:0] fx_gross;
    logic                merge_busy;

    assign cfg_ready  = 1'b1;
    assign item_stall = base_busy || base_done || merge_busy;
    assign start      = item_valid && !item_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mean_reg  <= '0;
            base_omega_reg <= V'(1);
            base_alpha_reg <= '0;
            base_beta_reg  <= '0;
            fx_mean_reg    <= '0;
            fx_omega_reg   <= '0;
            fx_alpha_reg   <= '0;
            fx_beta_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gbp_pkg::CFG_BASE_MEAN:  base_mean_reg  <= cfg_data[W-1:0];
                gbp_pkg::CFG_BASE_OMEGA: base_omega_reg <= cfg_data[V-1:0];
                gbp_pkg::CFG_BASE_ALPHA: base_alpha_reg <= cfg_data[C-1:0];
                gbp_pkg::CFG_BASE_BETA:  base_beta_reg  <= cfg_data[C-1:0];
                gbp_pkg::CFG_FX_MEAN:    fx_mean_reg    <= cfg_data[W-1:0];
                gbp_pkg::CFG_FX_OMEGA:   fx_omega_reg   <= cfg_data[V-1:0];
                gbp_pkg::CFG_FX_ALPHA:   fx_alpha_reg   <= cfg_data[C-1:0];
                gbp_pkg::CFG_FX_BETA:    fx_beta_reg    <= cfg_data[C-1:0];
                default:                 ;
            endcase
        end
    end

    // base series lane
    gbp_lane u_base
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .path_start (item.path_start),
        .init_var   (item.init_base_variance),
        .innovation (item.base_innovation),
        .mean       (base_mean_reg),
        .omega      (base_omega_reg),
        .alpha      (base_alpha_reg),
        .beta       (base_beta_reg),
        .busy       (base_busy),
        .done       (base_done),
        .gross      (base_gross)
    );

    // fx series lane
    gbp_lane u_fx
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .path_start (item.path_start),
        .init_var   (item.init_fx_variance),
        .innovation (item.fx_innovation),
        .mean       (fx_mean_reg),
        .omega      (fx_omega_reg),
        .alpha      (fx_alpha_reg),
        .beta       (fx_beta_reg),
        .busy       (fx_busy),
        .done       (fx_done),
        .gross      (fx_gross)
    );

    // cross product and output word
    gbp_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (base_done),
        .base_gross   (base_gross),
        .fx_gross     (fx_gross),
        .busy         (merge_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // both lanes run in lock step
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (base_done == fx_done) && (base_busy == fx_busy))
        else $error("lanes out of step");

    // an accepted word blocks the next one
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second word taken while a step runs");

    // a lane finishes only when the merge stage is free
    a_merge_free: assert property (@(posedge clk) disable iff (!rst_n)
        base_done |-> !merge_busy)
        else $error("lane result would overwrite pending product");
`endif

endmodule

@@ tb/sv/garch11_bootstrap_path_step_tb.sv @@
`timescale 1ns / 1ps

module garch11_bootstrap_path_step_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES = 7;
    localparam logic [63:0] VAR_FLOOR = 64'd281;
    localparam logic [47:0] VAR_MAX = {48{1'b1}};

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    gbp_pkg::item_t item;
    logic result_valid;
    logic result_stall;
    gbp_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gbp_pkg::CFG_DATA_W-1:0] cfg_data;

    garch11_bootstrap_path_step DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of registers and path state
    logic signed [31:0] m_base_mean, m_fx_mean;
    logic [47:0] m_base_omega, m_fx_omega, m_base_var, m_fx_var;
    logic [23:0] m_base_alpha, m_base_beta, m_fx_alpha, m_fx_beta;
    logic signed [31:0] m_base_shock, m_fx_shock;

    gbp_pkg::result_t expected_returns[$];
    int tx_idle, rx_idle, hold_req;
    int errors, items_sent, words_checked, cycles;

    typedef struct {
        gbp_pkg::item_t it;
        bit typed;
        gbp_pkg::result_t want;
    } stim_row_t;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d words pending", cycles,
                         expected_returns.size());
                $display("garch11_bootstrap_path_step_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // clamp a magnitude into the signed value range
    function automatic logic signed [31:0] clamp_mag(input logic [63:0] m, input bit neg);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (m > lim) m = lim;
        return neg ? -m[31:0] : m[31:0];
    endfunction

    function automatic logic [63:0] abs_val(input logic signed [31:0] x);
        logic signed [63:0] w;
        w = x;
        return (w < 0) ? -w : w;
    endfunction

    // one series: variance recursion, floor, sigma, shock, gross return
    function automatic logic signed [31:0] garch_series(inout logic [47:0] var_s,
        inout logic signed [31:0] shock, input logic [47:0] omega,
        input logic [23:0] alpha, input logic [23:0] beta,
        input logic signed [31:0] mean, input logic signed [31:0] z);
        logic [127:0] sq, asq, sum;
        logic [63:0] sm, v, sigma;
        longint g;
        sm = abs_val(shock);
        sq = sm * sm;
        asq = sq * alpha;
        if (asq[127:72] != 0) asq = 128'd1 << 72;
        sum = ({80'd0, omega} << 24) + asq + ({80'd0, var_s} * beta);
        sum = sum >> 24;
        v = (sum > VAR_MAX) ? {16'd0, VAR_MAX} : sum[63:0];
        if (v < VAR_FLOOR) v = VAR_FLOOR;
        var_s = v[47:0];
        sigma = root_floor(v);
        shock = clamp_mag((sigma * abs_val(z)) >> 24, z < 0);
        g = 64'sd16777216 + longint'(mean) + longint'(shock);
        if (g > 64'sd2147483647) g = 64'sd2147483647;
        if (g < -64'sd2147483648) g = -64'sd2147483648;
        return g[31:0];
    endfunction

    function automatic gbp_pkg::result_t predict_step(input gbp_pkg::item_t it);
        gbp_pkg::result_t r;
        logic signed [31:0] bg, fg;
        if (it.path_start)
        begin
            m_base_var = it.init_base_variance;
            m_fx_var = it.init_fx_variance;
            m_base_shock = '0;
            m_fx_shock = '0;
        end
        bg = garch_series(m_base_var, m_base_shock, m_base_omega, m_base_alpha,
                          m_base_beta, m_base_mean, it.base_innovation);
        fg = garch_series(m_fx_var, m_fx_shock, m_fx_omega, m_fx_alpha,
                          m_fx_beta, m_fx_mean, it.fx_innovation);
        r.base_gross_return = bg;
        r.cross_gross_return = clamp_mag((abs_val(bg) * abs_val(fg)) >> 24,
                                         (bg < 0) != (fg < 0));
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0t: %s mismatch got %h expected %h", $time, field, got, want);
    endtask

    // receiver: random stall, long hold-off on request, result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_returns.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected", $time);
            end
            else
            begin
                gbp_pkg::result_t w;
                w = expected_returns.pop_front();
                words_checked++;
                if (result.base_gross_return !== w.base_gross_return)
                    report_mismatch("base_gross_return", result.base_gross_return,
                                    w.base_gross_return);
                if (result.cross_gross_return !== w.cross_gross_return)
                    report_mismatch("cross_gross_return", result.cross_gross_return,
                                    w.cross_gross_return);
            end
        end
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_req > 0)
        begin
            hold_req--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < rx_idle);
    end

    task automatic write_reg(input gbp_pkg::cfg_index_t idx, input logic [47:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            gbp_pkg::CFG_BASE_MEAN:  m_base_mean = d[31:0];
            gbp_pkg::CFG_BASE_OMEGA: m_base_omega = d;
            gbp_pkg::CFG_BASE_ALPHA: m_base_alpha = d[23:0];
            gbp_pkg::CFG_BASE_BETA:  m_base_beta = d[23:0];
            gbp_pkg::CFG_FX_MEAN:    m_fx_mean = d[31:0];
            gbp_pkg::CFG_FX_OMEGA:   m_fx_omega = d;
            gbp_pkg::CFG_FX_ALPHA:   m_fx_alpha = d[23:0];
            gbp_pkg::CFG_FX_BETA:    m_fx_beta = d[23:0];
            default: ;
        endcase
    endtask

    // offer one word, hold until taken, then maybe leave a gap
    task automatic send_word(input gbp_pkg::item_t it, input bit typed,
                             input gbp_pkg::result_t want);
        gbp_pkg::result_t p;
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        p = predict_step(it);
        expected_returns.push_back(typed ? want : p);
        items_sent++;
        if ($urandom_range(99) < tx_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle) @(posedge clk);
        end
    endtask

    task automatic wait_drained;
        while (expected_returns.size() != 0) @(posedge clk);
    endtask

    function automatic gbp_pkg::item_t make_item(input bit ps, input logic [47:0] vb,
        input logic [47:0] vf, input logic [31:0] zb, input logic [31:0] zf);
        gbp_pkg::item_t it;
        it.path_start = ps;
        it.init_base_variance = vb;
        it.init_fx_variance = vf;
        it.base_innovation = zb;
        it.fx_innovation = zf;
        return it;
    endfunction

    function automatic logic [31:0] rand_innovation;
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(32'h0800_0000) - 32'h0400_0000;
    endfunction

    function automatic logic [47:0] rand48;
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] rand_variance;
        if ($urandom_range(2) == 0) return rand48();
        return {16'd0, $urandom} >> $urandom_range(16);
    endfunction

    // register set of one phase: typical, then two sets of extreme values, then random
    task automatic load_phase_regs(input int ph);
        logic [47:0] v[8];
        case (ph)
            1: v = '{48'h0000_0002_0000, 48'h0008_0000_0000, 48'h19_9999, 48'hD9_9999,
                     48'hFFFF_FFFF_0000, 48'h0004_0000_0000, 48'h0C_CCCC, 48'hE6_6666};
            2: v = '{48'h7FFF_FFFF, VAR_MAX, 48'hFF_FFFF, 48'hFF_FFFF,
                     48'h8000_0000, 48'd0, 48'd0, 48'hFF_FFFF};
            3: v = '{48'h8000_0000, 48'd1, 48'd0, 48'd0,
                     48'h7FFF_FFFF, 48'd0, 48'hFF_FFFF, 48'd0};
            default:
                v = '{rand48(), rand48() >> $urandom_range(30), rand48(), rand48(),
                      rand48(), rand48() >> $urandom_range(30), rand48(), rand48()};
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(gbp_pkg::cfg_index_t'(i), v[i]);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        stim_row_t rows[$];
        gbp_pkg::result_t unit;
        gbp_pkg::item_t it;
        errors = 0;
        items_sent = 0;
        words_checked = 0;
        hold_req = 0;
        tx_idle = 32;
        rx_idle = 47;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_base_mean = '0; m_base_omega = 48'd1; m_base_alpha = '0; m_base_beta = '0;
        m_fx_mean = '0; m_fx_omega = '0; m_fx_alpha = '0; m_fx_beta = '0;
        m_base_var = '0; m_fx_var = '0; m_base_shock = '0; m_fx_shock = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under reset registers: variance sits at the floor,
        // so a zero innovation gives a gross return of exactly one
        unit.base_gross_return = 32'h0100_0000;
        unit.cross_gross_return = 32'h0100_0000;
        rows.push_back('{make_item(1'b1, 48'd0, 48'd0, 32'd0, 32'd0), 1'b1, unit});
        rows.push_back('{make_item(1'b0, 48'd0, 48'd0, 32'd0, 32'd0), 1'b1, unit});
        rows.push_back('{make_item(1'b1, VAR_MAX, VAR_MAX, 32'd0, 32'd0), 1'b1, unit});
        rows.push_back('{make_item(1'b0, 48'd0, 48'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                         1'b0, unit});
        rows.push_back('{make_item(1'b0, 48'd0, 48'd0, 32'h8000_0000, 32'h8000_0000),
                         1'b0, unit});
        rows.push_back('{make_item(1'b0, 48'd0, 48'd0, 32'h7FFF_FFFF, 32'h8000_0000),
                         1'b0, unit});
        rows.push_back('{make_item(1'b0, 48'd0, 48'd0, 32'hFFFF_FFFF, 32'h0000_0001),
                         1'b0, unit});
        rows.push_back('{make_item(1'b1, VAR_MAX, 48'd0, 32'h0100_0000, 32'hFF00_0000),
                         1'b0, unit});
        rows.push_back('{make_item(1'b0, 48'd1, 48'd280, 32'h0300_0000, 32'h0300_0000),
                         1'b0, unit});
        for (int i = 0; i < rows.size(); i++)
            send_word(rows[i].it, rows[i].typed, rows[i].want);
        item_valid <= 1'b0;
        wait_drained();

        // random phases, each with its own register set
        for (int ph = 1; ph <= NUM_PHASES; ph++)
        begin
            tx_idle = (ph <= 2) ? 32 : (ph <= 4) ? 47 : 0;
            rx_idle = (ph <= 2) ? 47 : (ph <= 4) ? 32 : 0;
            load_phase_regs(ph);
            @(posedge clk);
            if (ph == 2) hold_req = 300;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it = make_item((n == 0) || ($urandom_range(19) == 0), rand_variance(),
                               rand_variance(), rand_innovation(), rand_innovation());
                send_word(it, 1'b0, unit);
                // sender pause until every word has come back
                if (ph == 5 && n == ITEMS_PER_PHASE / 2)
                begin
                    item_valid <= 1'b0;
                    wait_drained();
                end
            end
            item_valid <= 1'b0;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        $display("%0d words sent, %0d checked over %0d register sets", items_sent,
                 words_checked, NUM_PHASES + 1);
        $display("covered path starts, extreme innovations and register extremes");
        if (errors == 0 && expected_returns.size() == 0)
            $display("garch11_bootstrap_path_step_tb OK");
        else
            $display("garch11_bootstrap_path_step_tb NOT OK");
        $finish;
    end

endmodule
